// ===== rtl/e2c_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants
// State, command and status types plus the calendar constants used by the
// seconds-to-calendar controller and datapath.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // seconds per day, hour and minute
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // reciprocals of the odd part of each divisor
    // day    = ((secs >> 7) * DAY_RECIP)  >> 35, 86400 = 128 * 675
    // hour   = ((sod  >> 4) * HOUR_RECIP) >> 21, 3600  = 16 * 225
    // minute = ((soh  >> 2) * MIN_RECIP)  >> 14, 60    = 4 * 15
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    // first year and its residues mod 4, 100 and 400
    localparam logic [11:0] BASE_YEAR = 12'd1970;
    localparam logic [1:0]  Y4_BASE   = 2'd2;
    localparam logic [6:0]  Y100_BASE = 7'd70;
    localparam logic [8:0]  Y400_BASE = 9'd370;
    localparam logic [6:0]  Y100_LAST = 7'd99;
    localparam logic [8:0]  Y400_LAST = 9'd399;

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_QUO,
        ST_DAY_REM,
        ST_HOUR_QUO,
        ST_HOUR_REM,
        ST_MIN_QUO,
        ST_MIN_REM,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic day_quo;
        logic day_rem;
        logic hour_quo;
        logic hour_rem;
        logic min_quo;
        logic min_rem;
        logic year_step;
        logic month_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } t_status;

    // days in a month, february depends on the leap flag
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/e2c_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_dpath: conversion datapath
// Reciprocal multiply splits for day, hour and minute, year and month
// subtraction with leap tracking, and the result register.
// ----------------------------------------------------------------------------
module e2c_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire e2c_pkg::t_cmd     i_cmd,
    input  wire logic [31:0]       i_epoch_seconds,
    output e2c_pkg::t_status       o_status,
    output logic [11:0]            o_cal_year,
    output logic [3:0]             o_cal_month,
    output logic [4:0]             o_cal_day,
    output logic [4:0]             o_cal_hour,
    output logic [5:0]             o_cal_minute,
    output logic [5:0]             o_cal_second
);

    logic [31:0] r_secs,  n_secs;
    logic [15:0] r_days,  n_days;
    logic [16:0] r_sod,   n_sod;
    logic [4:0]  r_hour,  n_hour;
    logic [11:0] r_soh,   n_soh;
    logic [5:0]  r_min,   n_min;
    logic [5:0]  r_sec,   n_sec;
    logic [11:0] r_year,  n_year;
    logic [1:0]  r_y4,    n_y4;
    logic [6:0]  r_y100,  n_y100;
    logic [8:0]  r_y400,  n_y400;
    logic [3:0]  r_month, n_month;

    logic [50:0] w_day_prod;
    logic [31:0] w_day_secs;
    logic [31:0] w_sod;
    logic [25:0] w_hour_prod;
    logic [16:0] w_hour_secs;
    logic [16:0] w_soh;
    logic [19:0] w_min_prod;
    logic [11:0] w_min_secs;
    logic [11:0] w_sec;
    logic        w_leap;
    logic [8:0]  w_ylen;
    logic [4:0]  w_mlen;

    // day count by reciprocal multiply, then second of day
    assign w_day_prod = {26'd0, r_secs[31:7]} * {25'd0, e2c_pkg::DAY_RECIP};
    assign w_day_secs = {16'd0, r_days} * {15'd0, e2c_pkg::SECS_PER_DAY};
    assign w_sod      = r_secs - w_day_secs;

    // hour, then second of hour
    assign w_hour_prod = {13'd0, r_sod[16:4]} * {12'd0, e2c_pkg::HOUR_RECIP};
    assign w_hour_secs = {12'd0, r_hour} * {5'd0, e2c_pkg::SECS_PER_HOUR};
    assign w_soh       = r_sod - w_hour_secs;

    // minute, then second of minute
    assign w_min_prod = {10'd0, r_soh[11:2]} * {9'd0, e2c_pkg::MIN_RECIP};
    assign w_min_secs = {6'd0, r_min} * {6'd0, e2c_pkg::SECS_PER_MIN};
    assign w_sec      = r_soh - w_min_secs;

    // gregorian leap rule from the residue counters
    assign w_leap = (r_y4 == 2'd0) && ((r_y100 != 7'd0) || (r_y400 == 9'd0));
    assign w_ylen = w_leap ? e2c_pkg::DAYS_LEAP : e2c_pkg::DAYS_COMMON;
    assign w_mlen = e2c_pkg::month_len(r_month, w_leap);

    assign o_status.year_fit  = (r_days < {7'd0, w_ylen});
    assign o_status.month_fit = (r_month == e2c_pkg::MONTH_DEC) ||
                                (r_days < {11'd0, w_mlen});

    // next state of the working registers
    always_comb begin
        n_secs  = r_secs;
        n_days  = r_days;
        n_sod   = r_sod;
        n_hour  = r_hour;
        n_soh   = r_soh;
        n_min   = r_min;
        n_sec   = r_sec;
        n_year  = r_year;
        n_y4    = r_y4;
        n_y100  = r_y100;
        n_y400  = r_y400;
        n_month = r_month;

        if (i_cmd.load) begin
            n_secs  = i_epoch_seconds;
            n_year  = e2c_pkg::BASE_YEAR;
            n_y4    = e2c_pkg::Y4_BASE;
            n_y100  = e2c_pkg::Y100_BASE;
            n_y400  = e2c_pkg::Y400_BASE;
            n_month = e2c_pkg::MONTH_JAN;
        end

        if (i_cmd.day_quo) begin
            n_days = w_day_prod[50:35];
        end
        if (i_cmd.day_rem) begin
            n_sod = w_sod[16:0];
        end
        if (i_cmd.hour_quo) begin
            n_hour = w_hour_prod[25:21];
        end
        if (i_cmd.hour_rem) begin
            n_soh = w_soh[11:0];
        end
        if (i_cmd.min_quo) begin
            n_min = w_min_prod[19:14];
        end
        if (i_cmd.min_rem) begin
            n_sec = w_sec[5:0];
        end

        if (i_cmd.year_step) begin
            n_days = r_days - {7'd0, w_ylen};
            n_year = r_year + 12'd1;
            n_y4   = r_y4 + 2'd1;
            n_y100 = (r_y100 == e2c_pkg::Y100_LAST) ? 7'd0 : r_y100 + 7'd1;
            n_y400 = (r_y400 == e2c_pkg::Y400_LAST) ? 9'd0 : r_y400 + 9'd1;
        end

        if (i_cmd.month_step) begin
            n_days  = r_days - {11'd0, w_mlen};
            n_month = r_month + 4'd1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_secs  <= n_secs;
        r_days  <= n_days;
        r_sod   <= n_sod;
        r_hour  <= n_hour;
        r_soh   <= n_soh;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_year  <= n_year;
        r_y4    <= n_y4;
        r_y100  <= n_y100;
        r_y400  <= n_y400;
        r_month <= n_month;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_cal_year   <= r_year;
            o_cal_month  <= r_month;
            o_cal_day    <= r_days[4:0] + 5'd1;
            o_cal_hour   <= r_hour;
            o_cal_minute <= r_min;
            o_cal_second <= r_sec;
        end
    end

    // reset only matters for the controller, keep the port in use
    logic w_unused_rst;
    assign w_unused_rst = i_rst_n;

endmodule
`default_nettype wire

// ===== rtl/e2c_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_ctrl: conversion sequencer
// Steps the datapath through the time splits and the year and month walk, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module e2c_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire e2c_pkg::t_status  i_status,
    output e2c_pkg::t_cmd          o_cmd
);

    e2c_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= e2c_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == e2c_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            e2c_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = e2c_pkg::ST_DAY_QUO;
                end
            end
            e2c_pkg::ST_DAY_QUO: begin
                o_cmd.day_quo = 1'b1;
                n_state       = e2c_pkg::ST_DAY_REM;
            end
            e2c_pkg::ST_DAY_REM: begin
                o_cmd.day_rem = 1'b1;
                n_state       = e2c_pkg::ST_HOUR_QUO;
            end
            e2c_pkg::ST_HOUR_QUO: begin
                o_cmd.hour_quo = 1'b1;
                n_state        = e2c_pkg::ST_HOUR_REM;
            end
            e2c_pkg::ST_HOUR_REM: begin
                o_cmd.hour_rem = 1'b1;
                n_state        = e2c_pkg::ST_MIN_QUO;
            end
            e2c_pkg::ST_MIN_QUO: begin
                o_cmd.min_quo = 1'b1;
                n_state       = e2c_pkg::ST_MIN_REM;
            end
            e2c_pkg::ST_MIN_REM: begin
                o_cmd.min_rem = 1'b1;
                n_state       = e2c_pkg::ST_YEAR;
            end
            e2c_pkg::ST_YEAR: begin
                if (i_status.year_fit) begin
                    n_state = e2c_pkg::ST_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            e2c_pkg::ST_MONTH: begin
                if (i_status.month_fit) begin
                    n_state = e2c_pkg::ST_DONE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            e2c_pkg::ST_DONE: begin
                // hand over once the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = e2c_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = e2c_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
`default_nettype none
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// the Gregorian date and time of day. One item is worked on at a time: the day
// count, the hour and the minute are each split off by a reciprocal multiply
// followed by a multiply and subtract for the remainder, one step per cycle,
// then the year walk subtracts one year per cycle from 1970 and the month walk
// one month per cycle. The time to finish an item grows with the years past
// 1970 and the months past January, and is longest for December 2105. The
// input is ready again in the same cycle as the result is offered. A finished
// result sits in its own register, so the next item is taken while the
// previous result waits to be read; a second finished result holds off the
// input until the first one is read.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since epoch to calendar date and time
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [11:0]      o_cal_year,
    output logic [3:0]       o_cal_month,
    output logic [4:0]       o_cal_day,
    output logic [4:0]       o_cal_hour,
    output logic [5:0]       o_cal_minute,
    output logic [5:0]       o_cal_second
);

    e2c_pkg::t_cmd    w_cmd;
    e2c_pkg::t_status w_status;

    // sequencer
    e2c_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath
    e2c_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .o_status        (w_status),
        .o_cal_year      (o_cal_year),
        .o_cal_month     (o_cal_month),
        .o_cal_day       (o_cal_day),
        .o_cal_hour      (o_cal_hour),
        .o_cal_minute    (o_cal_minute),
        .o_cal_second    (o_cal_second)
    );

endmodule
`default_nettype wire

// ===== rtl/e2c_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_checker: port level checks
// Handshake and result range checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
module e2c_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [11:0] o_cal_year,
    input wire logic [3:0]  o_cal_month,
    input wire logic [4:0]  o_cal_day,
    input wire logic [4:0]  o_cal_hour,
    input wire logic [5:0]  o_cal_minute,
    input wire logic [5:0]  o_cal_second
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_cal_year) && $stable(o_cal_month) && $stable(o_cal_day) &&
            $stable(o_cal_hour) && $stable(o_cal_minute) && $stable(o_cal_second))
        else $error("result payload changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // every offered result has its fields in calendar range, the day only from below
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_cal_year >= 12'd1970) && (o_cal_year <= 12'd2106) &&
            (o_cal_month >= 4'd1) && (o_cal_month <= 4'd12) &&
            (o_cal_day >= 5'd1) && (o_cal_hour <= 5'd23) &&
            (o_cal_minute <= 6'd59) && (o_cal_second <= 6'd59))
        else $error("result out of calendar range");

endmodule

bind epoch_seconds_to_calendar e2c_checker u_e2c_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_cal_year   (o_cal_year),
    .o_cal_month  (o_cal_month),
    .o_cal_day    (o_cal_day),
    .o_cal_hour   (o_cal_hour),
    .o_cal_minute (o_cal_minute),
    .o_cal_second (o_cal_second)
);
`default_nettype wire
